// ----- hdl/voice_slot_allocator_top_assert.svh -----
// assertion macros for the voice slot allocator checker
`ifndef VOICE_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define VOICE_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define VSA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("voice slot allocator check failed");

// next-cycle implication, disabled during reset
`define VSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("voice slot allocator check failed");

`endif

// ----- hdl/vsa_pkg.sv -----
// shared types and constants for the voice slot allocator
`default_nettype none

package vsa_pkg;

	localparam int NOTE_W = 7;
	localparam int CHAN_W = 4;
	localparam int POS_W  = 3;
	localparam int SLOT_W = 3;
	localparam int VEL_W  = 7;
	localparam int CMD_W  = 3;

	localparam logic [VEL_W-1:0] FIXED_VELOCITY = 7'd100;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 3'd0,
		CMD_FREE  = 3'd1,
		CMD_QUERY = 3'd2,
		CMD_GET   = 3'd3,
		CMD_CLEAR = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [CHAN_W-1:0] channel;
	} slot_data_t;

endpackage

`default_nettype wire

// ----- hdl/voice_slot_allocator_top.sv -----
// voice slot allocator top level: slot table memory and command sequencer
//
// usage:
//   raise start with command, note, channel, mark_active and position; the
//   item is taken at a rising edge where start is high and busy is low.
//   one result per item appears on ok, slot and out_*, marked by done, which
//   is high for a single cycle; it cannot be held off.
// scan:
//   add, free, query and get nth scan the slot memory one entry per cycle,
//   pipelined over its registered read; the scan ends at the first hit or at
//   the last slot, and done is raised from the apply state that follows.
//   busy stays high until the edge that raises done.
//   clear and the unused codes give done on the next cycle and leave busy low.
// items:
//   one item at a time; a scanning item keeps busy high through its
//   sequential scan over the single memory read port.
// reset:
//   arst_n clears all active flags, the steal pointer and the sequencer; the
//   memory keeps stale contents that are only read behind a set active flag.
`default_nettype none

module voice_slot_allocator_top
	import vsa_pkg::*;
#(
	parameter int VOICE_COUNT = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [NOTE_W-1:0] note,
	input  wire logic [CHAN_W-1:0] channel,
	input  wire logic              mark_active,
	input  wire logic [POS_W-1:0]  position,
	output logic                   done,
	output logic                   ok,
	output logic [SLOT_W-1:0]      slot,
	output logic [NOTE_W-1:0]      out_note,
	output logic [CHAN_W-1:0]      out_channel,
	output logic [VEL_W-1:0]       out_velocity,
	output logic                   out_active
);

	localparam int IW = $clog2(VOICE_COUNT);

	logic          ram_wr_en;
	logic [IW-1:0] ram_wr_addr;
	slot_data_t    ram_wr_data;
	logic          ram_rd_en;
	logic [IW-1:0] ram_rd_addr;
	slot_data_t    ram_rd_data;

	vsa_slot_ram #(
		.DEPTH (VOICE_COUNT),
		.AW    (IW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	vsa_ctrl #(
		.VOICE_COUNT (VOICE_COUNT),
		.IW          (IW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.note         (note),
		.channel      (channel),
		.mark_active  (mark_active),
		.position     (position),
		.ram_wr_en    (ram_wr_en),
		.ram_wr_addr  (ram_wr_addr),
		.ram_wr_data  (ram_wr_data),
		.ram_rd_en    (ram_rd_en),
		.ram_rd_addr  (ram_rd_addr),
		.ram_rd_data  (ram_rd_data),
		.done         (done),
		.ok           (ok),
		.slot         (slot),
		.out_note     (out_note),
		.out_channel  (out_channel),
		.out_velocity (out_velocity),
		.out_active   (out_active)
	);

endmodule

`default_nettype wire

// ----- hdl/vsa_slot_ram.sv -----
// slot table memory: one write port, one registered read port
`default_nettype none

module vsa_slot_ram
	import vsa_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire logic       clk,
	input  wire logic       wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire slot_data_t wr_data,
	input  wire logic       rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output slot_data_t      rd_data
);

	slot_data_t mem_q [DEPTH];
	slot_data_t rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_s1;

endmodule

`default_nettype wire

// ----- hdl/vsa_ctrl.sv -----
// command sequencer: slot scan, active flags, steal pointer and result registers
`default_nettype none

module vsa_ctrl
	import vsa_pkg::*;
#(
	parameter int VOICE_COUNT = 8,
	parameter int IW          = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [NOTE_W-1:0] note,
	input  wire logic [CHAN_W-1:0] channel,
	input  wire logic              mark_active,
	input  wire logic [POS_W-1:0]  position,
	output logic                   ram_wr_en,
	output logic [IW-1:0]          ram_wr_addr,
	output slot_data_t             ram_wr_data,
	output logic                   ram_rd_en,
	output logic [IW-1:0]          ram_rd_addr,
	input  wire slot_data_t        ram_rd_data,
	output logic                   done,
	output logic                   ok,
	output logic [SLOT_W-1:0]      slot,
	output logic [NOTE_W-1:0]      out_note,
	output logic [CHAN_W-1:0]      out_channel,
	output logic [VEL_W-1:0]       out_velocity,
	output logic                   out_active
);

	localparam logic [IW-1:0] LAST = IW'(VOICE_COUNT - 1);

	state_t             state_q, state_d;
	logic [CMD_W-1:0]   cmd_q;
	logic [NOTE_W-1:0]  note_q;
	logic [CHAN_W-1:0]  chan_q;
	logic               mark_q;
	logic [POS_W-1:0]   pos_q;
	logic [IW-1:0]      scan_idx_q;
	logic               issue_end_q;
	logic               vld_s1;
	logic [IW-1:0]      idx_s1;
	logic [POS_W-1:0]   seen_q;
	logic               found_q;
	logic [IW-1:0]      hit_idx_q;
	logic [NOTE_W-1:0]  hit_note_q;
	logic [CHAN_W-1:0]  hit_chan_q;
	logic [VOICE_COUNT-1:0] active_q;
	logic [IW-1:0]      steal_q;
	logic               done_q;
	logic               ok_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [NOTE_W-1:0]  out_note_q;
	logic [CHAN_W-1:0]  out_chan_q;
	logic [VEL_W-1:0]   out_vel_q;
	logic               out_act_q;

	logic               accept;
	logic               scan_cmd;
	logic               issue;
	logic               act_b;
	logic               hit;
	logic               last_s1;
	logic               apply;
	logic               get_hit;
	logic [IW-1:0]      wr_idx;
	logic [IW+SLOT_W-1:0] wr_ext;
	logic [IW+SLOT_W-1:0] hit_ext;

	always_comb begin
		accept   = start && (state_q == ST_IDLE);
		issue    = (state_q == ST_SCAN) && !issue_end_q;
		apply    = (state_q == ST_APPLY);
		act_b    = active_q[idx_s1];
		last_s1  = (idx_s1 == LAST);
		wr_idx   = found_q ? hit_idx_q : steal_q;
		wr_ext   = {{SLOT_W{1'b0}}, wr_idx};
		hit_ext  = {{SLOT_W{1'b0}}, hit_idx_q};
		get_hit  = (cmd_q == CMD_GET) && found_q;
		case (command)
			CMD_ADD, CMD_FREE, CMD_QUERY, CMD_GET: begin
				scan_cmd = 1'b1;
			end
			default: begin
				scan_cmd = 1'b0;
			end
		endcase
		case (cmd_q)
			CMD_ADD: begin
				hit = !act_b;
			end
			CMD_FREE, CMD_QUERY: begin
				hit = act_b && (ram_rd_data.note == note_q);
			end
			CMD_GET: begin
				hit = act_b && (seen_q == pos_q);
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && scan_cmd) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (vld_s1 && (hit || last_s1)) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_idx_q  <= '0;
			issue_end_q <= 1'b0;
			vld_s1      <= 1'b0;
			seen_q      <= '0;
			found_q     <= 1'b0;
			active_q    <= '0;
			steal_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && !scan_cmd) || apply;
			vld_s1  <= issue;
			if (accept) begin
				scan_idx_q  <= '0;
				issue_end_q <= 1'b0;
				seen_q      <= '0;
				found_q     <= 1'b0;
				if (command == CMD_CLEAR) begin
					active_q <= '0;
					steal_q  <= '0;
				end
			end
			if (issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (scan_idx_q == LAST) begin
					issue_end_q <= 1'b1;
				end
			end
			if ((state_q == ST_SCAN) && vld_s1) begin
				if (hit) begin
					found_q <= 1'b1;
				end else if ((cmd_q == CMD_GET) && act_b) begin
					seen_q <= seen_q + 1'b1;
				end
			end
			if (apply) begin
				if (cmd_q == CMD_ADD) begin
					active_q[wr_idx] <= mark_q;
					if (!found_q) begin
						steal_q <= (steal_q == LAST) ? '0 : steal_q + 1'b1;
					end
				end else if ((cmd_q == CMD_FREE) && found_q) begin
					active_q[hit_idx_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (accept) begin
			cmd_q  <= command;
			note_q <= note;
			chan_q <= channel;
			mark_q <= mark_active;
			pos_q  <= position;
			if (!scan_cmd) begin
				ok_q       <= 1'b0;
				slot_q     <= '0;
				out_note_q <= '0;
				out_chan_q <= '0;
				out_vel_q  <= '0;
				out_act_q  <= 1'b0;
			end
		end
		if ((state_q == ST_SCAN) && vld_s1 && hit) begin
			hit_idx_q  <= idx_s1;
			hit_note_q <= ram_rd_data.note;
			hit_chan_q <= ram_rd_data.channel;
		end
		if (apply) begin
			ok_q <= found_q;
			if (cmd_q == CMD_ADD) begin
				slot_q <= wr_ext[SLOT_W-1:0];
			end else begin
				slot_q <= found_q ? hit_ext[SLOT_W-1:0] : '0;
			end
			out_note_q <= get_hit ? hit_note_q : '0;
			out_chan_q <= get_hit ? hit_chan_q : '0;
			out_vel_q  <= get_hit ? FIXED_VELOCITY : '0;
			out_act_q  <= get_hit;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign ram_rd_en    = issue;
	assign ram_rd_addr  = scan_idx_q;
	assign ram_wr_en    = apply && (cmd_q == CMD_ADD);
	assign ram_wr_addr  = wr_idx;
	assign ram_wr_data  = '{note: note_q, channel: chan_q};
	assign done         = done_q;
	assign ok           = ok_q;
	assign slot         = slot_q;
	assign out_note     = out_note_q;
	assign out_channel  = out_chan_q;
	assign out_velocity = out_vel_q;
	assign out_active   = out_act_q;

endmodule

`default_nettype wire

// ----- hdl/vsa_checker.sv -----
// port-level assertion checker for the voice slot allocator, with its bind
`default_nettype none
`include "voice_slot_allocator_top_assert.svh"

module vsa_checker
	import vsa_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic [CMD_W-1:0]  command,
	input wire logic              done,
	input wire logic              ok,
	input wire logic [NOTE_W-1:0] out_note,
	input wire logic [CHAN_W-1:0] out_channel,
	input wire logic [VEL_W-1:0]  out_velocity,
	input wire logic              out_active
);

	logic scan_item;

	assign scan_item = (command == CMD_ADD) || (command == CMD_FREE) ||
		(command == CMD_QUERY) || (command == CMD_GET);

	// a scanning item holds the block busy
	`VSA_ASSERT_NEXT(a_scan_busy, start && !busy && scan_item, busy)

	// busy only ends with a result
	`VSA_ASSERT_NOW(a_busy_end_done, $fell(busy), done)

	// a returned slot is found and carries the fixed velocity
	`VSA_ASSERT_NOW(a_active_found, done && out_active, ok && (out_velocity == FIXED_VELOCITY))

	// an empty result carries no slot contents
	`VSA_ASSERT_NOW(a_empty_zero, done && !out_active, {out_note, out_channel, out_velocity} == '0)

endmodule

bind voice_slot_allocator_top vsa_checker u_vsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.done         (done),
	.ok           (ok),
	.out_note     (out_note),
	.out_channel  (out_channel),
	.out_velocity (out_velocity),
	.out_active   (out_active)
);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for voice_slot_allocator_top: directed table, then random command mix
module testbench;
	import vsa_pkg::*;

	localparam int VOICES = 8;
	localparam int PERIOD = 12;
	localparam int PLAN_ROWS = 25;
	localparam int RANDOM_ITEMS = 1525;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_LIMIT = 20;
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'(CMD_CLEAR + 1);
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [NOTE_W-1:0] note;
		logic [CHAN_W-1:0] channel;
		logic              mark_active;
		logic [POS_W-1:0]  position;
	} voice_cmd_t;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] slot;
		logic [NOTE_W-1:0] note;
		logic [CHAN_W-1:0] channel;
		logic [VEL_W-1:0]  velocity;
		logic              active;
	} voice_result_t;

	typedef struct packed {
		voice_cmd_t    cmd;
		logic          fixed;
		voice_result_t want;
	} plan_row_t;

	localparam voice_result_t NO_RESULT = '0;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CMD_W-1:0]  command;
	logic [NOTE_W-1:0] note;
	logic [CHAN_W-1:0] channel;
	logic              mark_active;
	logic [POS_W-1:0]  position;
	logic              done;
	logic              ok;
	logic [SLOT_W-1:0] slot;
	logic [NOTE_W-1:0] out_note;
	logic [CHAN_W-1:0] out_channel;
	logic [VEL_W-1:0]  out_velocity;
	logic              out_active;

	logic [NOTE_W-1:0] held_note [VOICES] = '{default: '0};
	logic [CHAN_W-1:0] held_channel [VOICES] = '{default: '0};
	logic              held_active [VOICES] = '{default: 1'b0};
	int                steal_slot = 0;

	voice_result_t     pending_results[$];
	voice_result_t     got;
	voice_result_t     want;
	int                errors = 0;
	int                items_sent = 0;
	int                results_checked = 0;
	int                steals = 0;
	int                get_hits = 0;
	int                clears = 0;
	int                cycles = 0;

	plan_row_t plan [PLAN_ROWS] = '{
		'{'{CMD_QUERY, 7'd0, 4'd0, 1'b0, 3'd0}, 1'b1, NO_RESULT},
		'{'{CMD_GET, 7'd0, 4'd0, 1'b0, 3'd0}, 1'b1, NO_RESULT},
		'{'{CMD_FREE, 7'd127, 4'd0, 1'b0, 3'd0}, 1'b1, NO_RESULT},
		'{'{CMD_ADD, 7'd127, 4'd15, 1'b1, 3'd7}, 1'b1, '{1'b1, 3'd0, 7'd0, 4'd0, 7'd0, 1'b0}},
		'{'{CMD_ADD, 7'd0, 4'd0, 1'b0, 3'd0}, 1'b1, '{1'b1, 3'd1, 7'd0, 4'd0, 7'd0, 1'b0}},
		'{'{CMD_ADD, 7'd5, 4'd3, 1'b1, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_ADD, 7'd10, 4'd4, 1'b1, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_ADD, 7'd20, 4'd5, 1'b1, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_ADD, 7'd5, 4'd6, 1'b1, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_ADD, 7'd40, 4'd7, 1'b1, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_ADD, 7'd50, 4'd8, 1'b1, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_ADD, 7'd60, 4'd9, 1'b1, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_ADD, 7'd99, 4'd10, 1'b1, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_ADD, 7'd64, 4'd11, 1'b1, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_GET, 7'd0, 4'd0, 1'b0, 3'd7}, 1'b0, NO_RESULT},
		'{'{CMD_GET, 7'd0, 4'd0, 1'b0, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_QUERY, 7'd99, 4'd0, 1'b0, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_FREE, 7'd5, 4'd0, 1'b0, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_FREE, 7'd99, 4'd0, 1'b0, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_FREE, 7'd99, 4'd0, 1'b0, 3'd0}, 1'b0, NO_RESULT},
		'{'{CMD_SPARE_LO, 7'd0, 4'd0, 1'b0, 3'd0}, 1'b1, NO_RESULT},
		'{'{CMD_SPARE_HI, 7'd127, 4'd15, 1'b1, 3'd7}, 1'b1, NO_RESULT},
		'{'{CMD_CLEAR, 7'd0, 4'd0, 1'b0, 3'd0}, 1'b1, NO_RESULT},
		'{'{CMD_GET, 7'd0, 4'd0, 1'b0, 3'd7}, 1'b1, NO_RESULT},
		'{'{CMD_ADD, 7'd1, 4'd1, 1'b1, 3'd0}, 1'b1, '{1'b1, 3'd0, 7'd0, 4'd0, 7'd0, 1'b0}}
	};

	voice_slot_allocator_top #(
		.VOICE_COUNT(VOICES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.note(note),
		.channel(channel),
		.mark_active(mark_active),
		.position(position),
		.done(done),
		.ok(ok),
		.slot(slot),
		.out_note(out_note),
		.out_channel(out_channel),
		.out_velocity(out_velocity),
		.out_active(out_active)
	);

	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	function automatic voice_result_t allocate_voice(voice_cmd_t c);
		voice_result_t r;
		int idx;
		int seen;
		r = '0;
		idx = VOICES;
		seen = 0;
		case (c.command)
		CMD_ADD: begin
			for (int i = VOICES - 1; i >= 0; i--)
				if (!held_active[i])
					idx = i;
			if (idx < VOICES) begin
				r.ok = 1'b1;
			end else begin
				idx = steal_slot;
				steal_slot = (steal_slot + 1) % VOICES;
				steals++;
			end
			held_note[idx] = c.note;
			held_channel[idx] = c.channel;
			held_active[idx] = c.mark_active;
			r.slot = SLOT_W'(idx);
		end
		CMD_FREE, CMD_QUERY: begin
			for (int i = VOICES - 1; i >= 0; i--)
				if (held_active[i] && held_note[i] == c.note)
					idx = i;
			if (idx < VOICES) begin
				if (c.command == CMD_FREE)
					held_active[idx] = 1'b0;
				r.ok = 1'b1;
				r.slot = SLOT_W'(idx);
			end
		end
		CMD_GET: begin
			for (int i = 0; i < VOICES; i++) begin
				if (held_active[i] && idx == VOICES) begin
					if (seen == int'(c.position))
						idx = i;
					else
						seen++;
				end
			end
			if (idx < VOICES) begin
				r.ok = 1'b1;
				r.slot = SLOT_W'(idx);
				r.note = held_note[idx];
				r.channel = held_channel[idx];
				r.velocity = FIXED_VELOCITY;
				r.active = 1'b1;
				get_hits++;
			end
		end
		CMD_CLEAR: begin
			for (int i = 0; i < VOICES; i++) begin
				held_note[i] = '0;
				held_channel[i] = '0;
				held_active[i] = 1'b0;
			end
			steal_slot = 0;
			clears++;
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	task automatic issue(input voice_cmd_t c, input logic fixed, input voice_result_t typed);
		voice_result_t predicted;
		@(negedge clk);
		start <= 1'b1;
		command <= c.command;
		note <= c.note;
		channel <= c.channel;
		mark_active <= c.mark_active;
		position <= c.position;
		do @(posedge clk); while (busy);
		predicted = allocate_voice(c);
		pending_results.push_back(fixed ? typed : predicted);
		items_sent++;
	endtask

	task automatic pause(input int span);
		@(negedge clk);
		start <= 1'b0;
		command <= CMD_W'($urandom);
		note <= NOTE_W'($urandom);
		channel <= CHAN_W'($urandom);
		mark_active <= 1'(($urandom));
		position <= POS_W'($urandom);
		repeat (span - 1) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			got = '{ok, slot, out_note, out_channel, out_velocity, out_active};
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("%0t: unexpected item: ok=%0d slot=%0d note=%0d ch=%0d vel=%0d act=%0d",
						$time, got.ok, got.slot, got.note, got.channel, got.velocity,
						got.active);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got !== want) begin
					errors++;
					if (errors <= SHOW_LIMIT) begin
						$display("%0t: mismatch, expected ok=%0d slot=%0d note=%0d ch=%0d vel=%0d act=%0d",
							$time, want.ok, want.slot, want.note, want.channel, want.velocity,
							want.active);
						$display("%0t: mismatch, actual   ok=%0d slot=%0d note=%0d ch=%0d vel=%0d act=%0d",
							$time, got.ok, got.slot, got.note, got.channel, got.velocity,
							got.active);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("voice_slot_allocator_top regression: fail");
			$finish;
		end
	end

	initial begin
		voice_cmd_t c;
		logic [NOTE_W-1:0] note_pool [6];
		int pick;
		int add_share;
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		note = '0;
		channel = '0;
		mark_active = 1'b0;
		position = '0;
		for (int i = 0; i < 6; i++)
			note_pool[i] = NOTE_W'($urandom);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			issue(plan[i].cmd, plan[i].fixed, plan[i].want);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			// alternate churn phases with fill-heavy phases that force stealing
			add_share = ((k / 50) % 2) ? 56 : 36;
			pick = $urandom_range(0, 99);
			if (pick < add_share)
				c.command = CMD_ADD;
			else if (pick < add_share + 18)
				c.command = CMD_FREE;
			else if (pick < add_share + 30)
				c.command = CMD_QUERY;
			else if (pick < 97)
				c.command = CMD_GET;
			else if (pick < 98)
				c.command = CMD_CLEAR;
			else
				c.command = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			c.note = ($urandom_range(0, 3) != 0) ? note_pool[$urandom_range(0, 5)]
				: NOTE_W'($urandom);
			c.channel = CHAN_W'($urandom);
			c.mark_active = ($urandom_range(0, 99) < 85);
			c.position = POS_W'($urandom);
			if (k == 400) begin
				@(negedge clk);
				start <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end else if ((k < 700 || k >= 1100) && $urandom_range(0, 99) < 8) begin
				pause($urandom_range(1, 14));
			end
			issue(c, 1'b0, NO_RESULT);
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (VOICES + 8) @(posedge clk);

		$display("covered %0d items and %0d checked results: %0d steals, %0d get hits, %0d clears",
			items_sent, results_checked, steals, get_hits, clears);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("voice_slot_allocator_top regression: pass");
		end else begin
			$display("%0d errors, %0d results outstanding", errors, pending_results.size());
			$display("voice_slot_allocator_top regression: fail");
		end
		$finish;
	end

endmodule
